// ===== rtl/sbt_pkg.sv =====
// shared types, constants and keyword tables of the source byte tokenizer
`default_nettype none

package sbt_pkg;

  localparam int unsigned PositionBitsDef = 16;
  localparam int unsigned FifoDepth       = 2;
  localparam logic [15:0] LenMax          = 16'hFFFF;
  localparam logic [15:0] LineMax         = 16'hFFFF;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_NUM   = 3'd1,
    MODE_IDENT = 3'd2,
    MODE_C3    = 3'd3,
    MODE_C2    = 3'd4
  } scan_mode_e;

  typedef enum logic [4:0] {
    TK_LPAREN    = 5'd0,
    TK_RPAREN    = 5'd1,
    TK_LBRACE    = 5'd2,
    TK_RBRACE    = 5'd3,
    TK_SEMI      = 5'd4,
    TK_DOT       = 5'd5,
    TK_PLUS      = 5'd6,
    TK_MINUS     = 5'd7,
    TK_ASSIGN    = 5'd8,
    TK_MULTIPLY  = 5'd9,
    TK_DIVIDE    = 5'd10,
    TK_POWER     = 5'd11,
    TK_NUMBER    = 5'd12,
    TK_IDENT     = 5'd13,
    TK_SUBJECT   = 5'd14,
    TK_FONKSIYON = 5'd15,
    TK_DEGISKEN  = 5'd16,
    TK_DON       = 5'd17,
    TK_EOF       = 5'd18,
    TK_ERROR     = 5'd19
  } token_kind_e;

  // one token, kind in the low bits
  typedef struct packed {
    logic [15:0] line;
    logic [15:0] length;
    logic [15:0] start;
    token_kind_e kind;
  } token_t;

  // all tokens caused by one request
  typedef struct packed {
    logic   two;
    token_t first;
    token_t second;
  } token_pair_t;

  localparam logic [7:0] ByteLead2  = 8'hC2;
  localparam logic [7:0] ByteLead3  = 8'hC3;
  localparam logic [7:0] ByteDivide = 8'hB7;
  localparam logic [7:0] BytePow1   = 8'hB9;
  localparam logic [7:0] BytePow2   = 8'hB2;
  localparam logic [7:0] BytePow3   = 8'hB3;

  function automatic logic [15:0] kw_len(input logic [1:0] k);
    case (k)
      2'd0:    kw_len = 16'd7;
      2'd1:    kw_len = 16'd9;
      2'd2:    kw_len = 16'd8;
      default: kw_len = 16'd3;
    endcase
  endfunction

  function automatic token_kind_e kw_kind(input logic [1:0] k);
    case (k)
      2'd0:    kw_kind = TK_SUBJECT;
      2'd1:    kw_kind = TK_FONKSIYON;
      2'd2:    kw_kind = TK_DEGISKEN;
      default: kw_kind = TK_DON;
    endcase
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [3:0] idx);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      2'd0: begin
        case (idx)
          4'd0: c = "s"; 4'd1: c = "u"; 4'd2: c = "b"; 4'd3: c = "j";
          4'd4: c = "e"; 4'd5: c = "c"; 4'd6: c = "t";
          default: c = 8'h00;
        endcase
      end
      2'd1: begin
        case (idx)
          4'd0: c = "f"; 4'd1: c = "o"; 4'd2: c = "n"; 4'd3: c = "k";
          4'd4: c = "s"; 4'd5: c = "i"; 4'd6: c = "y"; 4'd7: c = "o";
          4'd8: c = "n";
          default: c = 8'h00;
        endcase
      end
      2'd2: begin
        case (idx)
          4'd0: c = "d"; 4'd1: c = "e"; 4'd2: c = "g"; 4'd3: c = "i";
          4'd4: c = "s"; 4'd5: c = "k"; 4'd6: c = "e"; 4'd7: c = "n";
          default: c = 8'h00;
        endcase
      end
      default: begin
        case (idx)
          4'd0: c = "d"; 4'd1: c = "o"; 4'd2: c = "n";
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  // keyword k still matches when byte b lands at offset idx
  function automatic logic kw_hit(input logic [1:0] k, input logic [15:0] idx,
                                  input logic [7:0] b);
    logic hit;
    hit = 1'b0;
    if (idx < kw_len(k)) begin
      hit = (kw_char(k, idx[3:0]) == b);
    end
    return hit;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == LenMax) ? v : v + 16'd1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sbt_scanner.sv =====
// scan state and per-byte token logic of the source byte tokenizer
`default_nettype none

module sbt_scanner import sbt_pkg::*; #(
  parameter int unsigned PositionBits = PositionBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        op_i,
  input  wire logic [7:0]  byte_i,
  output token_pair_t      pair_o,
  output logic             pair_valid_o
);

  scan_mode_e              mode_q, mode_d;
  logic [PositionBits-1:0] pos_q, pos_d;
  logic [PositionBits-1:0] pstart_q, pstart_d;
  logic [15:0]             plen_q, plen_d;
  logic [15:0]             line_q, line_d;
  logic [3:0]              kalive_q, kalive_d;

  always_comb begin
    logic        is_dig;
    logic        is_alp;
    logic        fl_v;
    logic        sc_v;
    token_t      fl_r;
    token_t      sc_r;
    logic        do_fresh;
    logic [15:0] here16;

    is_dig   = (byte_i >= "0") && (byte_i <= "9");
    is_alp   = ((byte_i >= "A") && (byte_i <= "Z")) || ((byte_i >= "a") && (byte_i <= "z"));
    here16   = 16'(pos_q);
    mode_d   = mode_q;
    pos_d    = pos_q;
    pstart_d = pstart_q;
    plen_d   = plen_q;
    line_d   = line_q;
    kalive_d = kalive_q;
    do_fresh = 1'b0;

    // pending token as it would be flushed
    fl_v        = 1'b0;
    fl_r.line   = line_q;
    fl_r.start  = 16'(pstart_q);
    fl_r.length = plen_q;
    fl_r.kind   = TK_IDENT;
    case (mode_q)
      MODE_NUM: begin
        fl_v      = 1'b1;
        fl_r.kind = TK_NUMBER;
      end
      MODE_IDENT: begin
        fl_v = 1'b1;
        for (int k = 0; k < 4; k++) begin
          if (kalive_q[k] && (plen_q == kw_len(2'(k)))) begin
            fl_r.kind = kw_kind(2'(k));
          end
        end
      end
      MODE_C3, MODE_C2: begin
        fl_v        = 1'b1;
        fl_r.kind   = TK_ERROR;
        fl_r.length = 16'd1;
      end
      default: fl_v = 1'b0;
    endcase

    sc_v        = 1'b0;
    sc_r.line   = line_q;
    sc_r.start  = here16;
    sc_r.length = 16'd1;
    sc_r.kind   = TK_ERROR;

    if (op_i) begin
      sc_v        = 1'b1;
      sc_r.kind   = TK_EOF;
      sc_r.length = 16'd0;
      mode_d      = MODE_IDLE;
      plen_d      = 16'd0;
      kalive_d    = 4'hF;
    end else begin
      pos_d = pos_q + 1'b1;
      if ((mode_q == MODE_NUM) && is_dig) begin
        fl_v   = 1'b0;
        plen_d = sat_inc(plen_q);
      end else if ((mode_q == MODE_IDENT) && (is_dig || is_alp)) begin
        fl_v = 1'b0;
        for (int k = 0; k < 4; k++) begin
          kalive_d[k] = kalive_q[k] & kw_hit(2'(k), plen_q, byte_i);
        end
        plen_d = sat_inc(plen_q);
      end else if ((mode_q == MODE_C3) && (byte_i == ByteDivide)) begin
        fl_v        = 1'b1;
        fl_r.kind   = TK_DIVIDE;
        fl_r.length = 16'd2;
        mode_d      = MODE_IDLE;
        plen_d      = 16'd0;
        kalive_d    = 4'hF;
      end else if ((mode_q == MODE_C2) &&
                   ((byte_i == BytePow1) || (byte_i == BytePow2) || (byte_i == BytePow3))) begin
        fl_v        = 1'b1;
        fl_r.kind   = TK_POWER;
        fl_r.length = 16'd2;
        mode_d      = MODE_IDLE;
        plen_d      = 16'd0;
        kalive_d    = 4'hF;
      end else begin
        do_fresh = 1'b1;
        mode_d   = MODE_IDLE;
        plen_d   = 16'd0;
        kalive_d = 4'hF;
      end
    end

    if (do_fresh) begin
      case (byte_i)
        "(": begin sc_v = 1'b1; sc_r.kind = TK_LPAREN;   end
        ")": begin sc_v = 1'b1; sc_r.kind = TK_RPAREN;   end
        "{": begin sc_v = 1'b1; sc_r.kind = TK_LBRACE;   end
        "}": begin sc_v = 1'b1; sc_r.kind = TK_RBRACE;   end
        ";": begin sc_v = 1'b1; sc_r.kind = TK_SEMI;     end
        ".": begin sc_v = 1'b1; sc_r.kind = TK_DOT;      end
        "+": begin sc_v = 1'b1; sc_r.kind = TK_PLUS;     end
        "-": begin sc_v = 1'b1; sc_r.kind = TK_MINUS;    end
        "=": begin sc_v = 1'b1; sc_r.kind = TK_ASSIGN;   end
        "x": begin sc_v = 1'b1; sc_r.kind = TK_MULTIPLY; end
        8'h20, 8'h0D, 8'h09: sc_v = 1'b0;
        8'h0A: begin
          if (line_q != LineMax) begin
            line_d = line_q + 16'd1;
          end
        end
        default: begin
          if (is_dig) begin
            mode_d   = MODE_NUM;
            pstart_d = pos_q;
            plen_d   = 16'd1;
          end else if (is_alp) begin
            mode_d   = MODE_IDENT;
            pstart_d = pos_q;
            plen_d   = 16'd1;
            for (int k = 0; k < 4; k++) begin
              kalive_d[k] = kw_hit(2'(k), 16'd0, byte_i);
            end
          end else if ((byte_i == ByteLead3) || (byte_i == ByteLead2)) begin
            mode_d   = (byte_i == ByteLead3) ? MODE_C3 : MODE_C2;
            pstart_d = pos_q;
            plen_d   = 16'd1;
          end else begin
            sc_v = 1'b1;
          end
        end
      endcase
    end

    // pack so that the flushed token goes out first
    pair_valid_o = fl_v | sc_v;
    if (fl_v) begin
      pair_o.two    = sc_v;
      pair_o.first  = fl_r;
      pair_o.second = sc_r;
    end else begin
      pair_o.two    = 1'b0;
      pair_o.first  = sc_r;
      pair_o.second = sc_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pos_q    <= '0;
      pstart_q <= '0;
      plen_q   <= 16'd0;
      line_q   <= 16'd1;
      kalive_q <= 4'hF;
    end else if (en_i) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      pstart_q <= pstart_d;
      plen_q   <= plen_d;
      line_q   <= line_d;
      kalive_q <= kalive_d;
    end
  end

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni) line_q != 16'd0)
    else $error("line count reached zero");

  a_eof_holds_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && op_i |=> $stable(pos_q))
    else $error("end of source moved the byte position");

endmodule

`default_nettype wire

// ===== rtl/sbt_res_fifo.sv =====
// token pair queue and serializer onto the output stream
`default_nettype none

module sbt_res_fifo import sbt_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         wr_valid_i,
  input  wire token_pair_t  wr_pair_i,
  output logic              wr_ready_o,
  output logic              m_valid_o,
  input  wire logic         m_ready_i,
  output token_t            m_token_o,
  output logic              m_last_o
);

  localparam int unsigned PtrBits = $clog2(FifoDepth);
  localparam int unsigned CntBits = $clog2(FifoDepth + 1);

  token_pair_t        mem_q [FifoDepth];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] count_q;
  logic               sub_q;
  token_pair_t        head;
  logic               push, pop_tok, pop_entry;

  assign head       = mem_q[rd_ptr_q];
  assign wr_ready_o = (count_q != CntBits'(FifoDepth));
  assign push       = wr_valid_i & wr_ready_o;
  assign m_valid_o  = (count_q != '0);
  assign m_token_o  = sub_q ? head.second : head.first;
  assign m_last_o   = sub_q | ~head.two;
  assign pop_tok    = m_valid_o & m_ready_i;
  assign pop_entry  = pop_tok & m_last_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_pair_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      sub_q    <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_entry) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push, pop_entry})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
      if (pop_tok) begin
        sub_q <= ~m_last_o;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(FifoDepth))
    else $error("queue count over depth");

  a_second_has_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q |-> (m_valid_o && head.two))
    else $error("second token selected from a single-token entry");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_valid_i && (count_q == CntBits'(FifoDepth)) |=> $stable(wr_ptr_q))
    else $error("write pointer moved while full");

endmodule

`default_nettype wire

// ===== rtl/source_byte_tokenizer.sv =====
// top level of the source byte tokenizer: request register, scanner, token queue
// path: a token passes the request register and then the queue before it leaves
// throughput: one request per cycle if the queue has room; two-token requests hold the output
// a request that yields no token still passes through the request register
// the 2-entry token queue lets requests continue while a token waits to be taken
// reset: scan idle, byte position 0, line 1, queue empty
`default_nettype none

module source_byte_tokenizer import sbt_pkg::*; #(
  parameter int unsigned PositionBits = PositionBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] source_byte
  input  wire logic        s_axis_tuser_i,   // [0] operation
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [55:0]      m_axis_tdata_o,   // [4:0] kind, [20:5] start, [36:21] length,
                                             // [52:37] line, [55:53] zero
  output logic             m_axis_tlast_o    // last_of_run
);

  logic        req_valid_q;
  logic        req_op_q;
  logic [7:0]  req_byte_q;
  logic        consume;
  logic        fifo_ready;
  logic        pair_valid;
  token_pair_t pair;
  token_t      out_tok;

  assign consume         = req_valid_q & fifo_ready;
  assign s_axis_tready_o = ~req_valid_q | consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      req_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      req_op_q   <= s_axis_tuser_i;
      req_byte_q <= s_axis_tdata_i;
    end
  end

  sbt_scanner #(
    .PositionBits(PositionBits)
  ) u_scanner (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (consume),
    .op_i        (req_op_q),
    .byte_i      (req_byte_q),
    .pair_o      (pair),
    .pair_valid_o(pair_valid)
  );

  sbt_res_fifo u_res_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(consume & pair_valid),
    .wr_pair_i (pair),
    .wr_ready_o(fifo_ready),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_token_o (out_tok),
    .m_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {3'b000, out_tok};

endmodule

`default_nettype wire

// ===== bench/token_stream_checker.sv =====
// token stream checker: predicts the tokens of each accepted request and compares the output
`timescale 1ns / 1ps

module token_stream_checker import sbt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] source_byte
  input  logic        s_axis_tuser_i,   // [0] operation
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [55:0] m_axis_tdata_i,   // [4:0] kind, [20:5] start, [36:21] length, [52:37] line
  input  logic        m_axis_tlast_i,
  output int          failures_o,
  output int          outstanding_o,
  output int          tokens_checked_o
);

  typedef struct {
    token_kind_e kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] line;
    logic        last;
  } token_rec_t;

  string kw_word [4] = '{"subject", "fonksiyon", "degisken", "don"};

  token_rec_t  tokens_due [$];
  token_rec_t  step_tokens [$];
  token_rec_t  want;
  int          fail_total = 0;
  int          checked = 0;

  scan_mode_e  mode;
  logic [15:0] byte_pos;
  logic [15:0] tok_start;
  logic [15:0] tok_len;
  logic [15:0] line_no;
  logic [3:0]  kw_live;

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  task automatic add_token(input token_kind_e kind, input logic [15:0] start,
                           input logic [15:0] length);
    token_rec_t t;
    t.kind   = kind;
    t.start  = start;
    t.length = length;
    t.line   = line_no;
    t.last   = 1'b0;
    step_tokens.insert(step_tokens.size(), t);
  endtask

  task automatic grow_word(input logic [7:0] b);
    for (int k = 0; k < 4; k++) begin
      if (tok_len >= kw_word[k].len() || kw_word[k][tok_len] != b) begin
        kw_live[k] = 1'b0;
      end
    end
    if (tok_len != LenMax) begin
      tok_len++;
    end
  endtask

  task automatic drop_token();
    mode    = MODE_IDLE;
    tok_len = '0;
    kw_live = 4'hF;
  endtask

  task automatic close_token();
    token_kind_e kind;
    case (mode)
      MODE_NUM: begin
        add_token(TK_NUMBER, tok_start, tok_len);
      end
      MODE_IDENT: begin
        kind = TK_IDENT;
        for (int k = 0; k < 4; k++) begin
          if (kw_live[k] && tok_len == kw_word[k].len()) begin
            kind = token_kind_e'(TK_SUBJECT + k);
          end
        end
        add_token(kind, tok_start, tok_len);
      end
      MODE_C3, MODE_C2: begin
        add_token(TK_ERROR, tok_start, 16'd1);
      end
      default: ;
    endcase
    drop_token();
  endtask

  task automatic fresh_byte(input logic [7:0] b, input logic [15:0] here);
    case (b)
      "(": add_token(TK_LPAREN, here, 16'd1);
      ")": add_token(TK_RPAREN, here, 16'd1);
      "{": add_token(TK_LBRACE, here, 16'd1);
      "}": add_token(TK_RBRACE, here, 16'd1);
      ";": add_token(TK_SEMI, here, 16'd1);
      ".": add_token(TK_DOT, here, 16'd1);
      "+": add_token(TK_PLUS, here, 16'd1);
      "-": add_token(TK_MINUS, here, 16'd1);
      "=": add_token(TK_ASSIGN, here, 16'd1);
      "x": add_token(TK_MULTIPLY, here, 16'd1);
      8'h20, 8'h0D, 8'h09: ;
      8'h0A: begin
        if (line_no != LineMax) begin
          line_no++;
        end
      end
      default: begin
        if (is_digit(b)) begin
          mode      = MODE_NUM;
          tok_start = here;
          tok_len   = 16'd1;
        end else if (is_letter(b)) begin
          mode      = MODE_IDENT;
          tok_start = here;
          tok_len   = '0;
          kw_live   = 4'hF;
          grow_word(b);
        end else if (b == ByteLead3 || b == ByteLead2) begin
          mode      = (b == ByteLead3) ? MODE_C3 : MODE_C2;
          tok_start = here;
          tok_len   = 16'd1;
        end else begin
          add_token(TK_ERROR, here, 16'd1);
        end
      end
    endcase
  endtask

  task automatic scan_request(input logic at_end, input logic [7:0] b);
    logic [15:0] here;
    here = byte_pos;
    step_tokens.delete();
    if (at_end) begin
      close_token();
      add_token(TK_EOF, here, 16'd0);
    end else begin
      if (mode == MODE_NUM && is_digit(b)) begin
        if (tok_len != LenMax) begin
          tok_len++;
        end
      end else if (mode == MODE_IDENT && (is_digit(b) || is_letter(b))) begin
        grow_word(b);
      end else if (mode == MODE_C3 && b == ByteDivide) begin
        add_token(TK_DIVIDE, tok_start, 16'd2);
        drop_token();
      end else if (mode == MODE_C2 && (b == BytePow1 || b == BytePow2 || b == BytePow3)) begin
        add_token(TK_POWER, tok_start, 16'd2);
        drop_token();
      end else begin
        close_token();
        fresh_byte(b, here);
      end
      byte_pos = here + 16'd1;
    end
    if (step_tokens.size() != 0) begin
      step_tokens[step_tokens.size() - 1].last = 1'b1;
    end
    foreach (step_tokens[i]) begin
      tokens_due.insert(tokens_due.size(), step_tokens[i]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode      = MODE_IDLE;
      byte_pos  = '0;
      tok_start = '0;
      tok_len   = '0;
      line_no   = 16'd1;
      kw_live   = 4'hF;
      tokens_due.delete();
      outstanding_o    <= 0;
      failures_o       <= fail_total;
      tokens_checked_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        checked++;
        if (tokens_due.size() == 0) begin
          $error("token with none expected: kind %0d start %0d", m_axis_tdata_i[4:0],
                 m_axis_tdata_i[20:5]);
          fail_total++;
        end else begin
          want = tokens_due.pop_front();
          if (m_axis_tdata_i[4:0] !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, m_axis_tdata_i[4:0]);
            fail_total++;
          end
          if (m_axis_tdata_i[20:5] !== want.start) begin
            $error("start: expected %0d, actual %0d", want.start, m_axis_tdata_i[20:5]);
            fail_total++;
          end
          if (m_axis_tdata_i[36:21] !== want.length) begin
            $error("length: expected %0d, actual %0d", want.length, m_axis_tdata_i[36:21]);
            fail_total++;
          end
          if (m_axis_tdata_i[52:37] !== want.line) begin
            $error("line: expected %0d, actual %0d", want.line, m_axis_tdata_i[52:37]);
            fail_total++;
          end
          if (m_axis_tlast_i !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, m_axis_tlast_i);
            fail_total++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        scan_request(s_axis_tuser_i, s_axis_tdata_i);
      end
      outstanding_o    <= tokens_due.size();
      failures_o       <= fail_total;
      tokens_checked_o <= checked;
    end
  end

endmodule

// ===== bench/testbench.sv =====
// testbench top: drives source bytes into the tokenizer and reports the verdict
`timescale 1ns / 1ps

module testbench import sbt_pkg::*;;

  localparam logic OpByte     = 1'b0;
  localparam logic OpEnd      = 1'b1;
  localparam int   RandomRun  = 1520;
  localparam int   HoldCycles = 400;
  localparam int   CycleLimit = 100_000;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = 8'h00;
  logic        s_axis_tuser_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [55:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  int   failures;
  int   outstanding;
  int   tokens_checked;
  int   items_sent = 0;
  int   cycles = 0;
  int   hold_left = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  logic steady = 1'b0;

  string      kw_list [4] = '{"subject", "fonksiyon", "degisken", "don"};
  string      punct = "(){};.+-=x";
  logic [7:0] blank [4] = '{8'h20, 8'h09, 8'h0D, 8'h0A};

  source_byte_tokenizer dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tlast_o
  );

  token_stream_checker u_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_i  (s_axis_tready_o),
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_i  (m_axis_tvalid_o),
    .m_axis_tready_i,
    .m_axis_tdata_i   (m_axis_tdata_o),
    .m_axis_tlast_i   (m_axis_tlast_o),
    .failures_o       (failures),
    .outstanding_o    (outstanding),
    .tokens_checked_o (tokens_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_axis_tready_i <= 1'b0;
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else begin
      m_axis_tready_i <= steady || ($urandom_range(99) >= 19);
    end
  end

  function automatic logic [7:0] letter();
    return $urandom_range(1) ? 8'("A" + $urandom_range(25)) : 8'("a" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  function automatic logic [7:0] word_char();
    return ($urandom_range(3) == 0) ? digit() : letter();
  endfunction

  task automatic offer(input logic op, input logic [7:0] b);
    while (!steady && $urandom_range(99) < 19) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= 8'($urandom);
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tuser_i  <= op;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic offer_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      offer(OpByte, s[i]);
    end
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic offer_fragment();
    logic [7:0] frag [$];
    string      w;
    int         pick;
    int         i;
    pick = $urandom_range(99);
    if (pick < 20) begin
      w = kw_list[$urandom_range(3)];
      for (i = 0; i < w.len(); i++) begin
        frag.insert(frag.size(), w[i]);
      end
      case ($urandom_range(3))
        1: repeat ($urandom_range(frag.size() - 1)) void'(frag.pop_back());
        2: frag.insert(frag.size(), word_char());
        3: frag[$urandom_range(frag.size() - 1)] = word_char();
        default: ;
      endcase
    end else if (pick < 35) begin
      frag.insert(frag.size(), letter());
      repeat ($urandom_range(10)) frag.insert(frag.size(), word_char());
    end else if (pick < 48) begin
      repeat ($urandom_range(6, 1)) frag.insert(frag.size(), digit());
    end else if (pick < 63) begin
      frag.insert(frag.size(), punct[$urandom_range(punct.len() - 1)]);
    end else if (pick < 75) begin
      frag.insert(frag.size(), blank[$urandom_range(3)]);
    end else if (pick < 83) begin
      if ($urandom_range(3) == 0) begin
        frag.insert(frag.size(), ByteLead3);
        frag.insert(frag.size(), ByteDivide);
      end else begin
        frag.insert(frag.size(), ByteLead2);
        case ($urandom_range(2))
          0:       frag.insert(frag.size(), BytePow1);
          1:       frag.insert(frag.size(), BytePow2);
          default: frag.insert(frag.size(), BytePow3);
        endcase
      end
    end else if (pick < 88) begin
      frag.insert(frag.size(), $urandom_range(1) ? ByteLead3 : ByteLead2);
      frag.insert(frag.size(), 8'($urandom));
    end else if (pick < 97) begin
      frag.insert(frag.size(), 8'($urandom));
    end else begin
      offer(OpEnd, 8'($urandom));
    end
    foreach (frag[j]) begin
      offer(OpByte, frag[j]);
    end
  endtask

  initial begin
    int directed_items;
    logic paused;
    paused = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // every single-byte token, blanks, number and identifier ended by a byte, divide and power pairs
    offer_text("(){};.+-=x \t");
    offer(OpByte, 8'h0D);
    offer_text("\n9Z(");
    offer(OpByte, ByteLead3);
    offer(OpByte, ByteDivide);
    offer(OpByte, ByteLead2);
    offer(OpByte, BytePow3);
    // broken pair, other bytes, lead byte pending at end, repeated end
    offer(OpByte, ByteLead3);
    offer(OpByte, "+");
    offer(OpByte, 8'hFF);
    offer(OpByte, 8'h00);
    offer(OpByte, ByteLead2);
    offer(OpEnd, 8'hA5);
    offer(OpEnd, 8'h00);
    directed_items = items_sent;

    while (items_sent < directed_items + RandomRun) begin
      if (!hold_req && items_sent > directed_items + 400) begin
        hold_req <= 1'b1;
      end
      steady <= (items_sent >= directed_items + 700) && (items_sent < directed_items + 900);
      if (!paused && items_sent > directed_items + 1100) begin
        drain();
        paused = 1'b1;
      end
      offer_fragment();
    end
    steady <= 1'b0;
    offer(OpEnd, 8'h00);

    drain();
    repeat (8) @(posedge clk_i);
    $display("ran %0d requests, checked %0d tokens", items_sent, tokens_checked);
    $display("covered all token kinds, broken pairs, end of source, hold-off and a full drain");
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
